### hdl/rcpiq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC pulse input qualifier package
// Shared transaction types, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package rcpiq_pkg;

  typedef enum logic [1:0] {
    CMD_CAPTURE = 2'd0,
    CMD_POLL    = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_EMIT
  } state_e;

  localparam logic KIND_SPEED = 1'b0;
  localparam logic KIND_IDLE  = 1'b1;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_MIN_WIDTH      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_OVERFLOW_LIMIT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GOOD_NEEDED    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_LIMIT     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_OFFSET  = 3'd4;

  localparam logic [15:0] MinWidthRst      = 16'd4000;
  localparam logic [15:0] OverflowLimitRst = 16'd25000;
  localparam logic [3:0]  GoodNeededRst    = 4'd10;
  localparam logic [7:0]  IdleLimitRst     = 8'd8;
  localparam logic [15:0] CenterOffsetRst  = 16'd15000;

  typedef struct packed {
    cmd_e        cmd;
    logic        channel;
    logic [15:0] pulse_width;
    logic        pin_high;
    logic [15:0] counter_value;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic               out_channel;
    logic signed [15:0] speed;
    logic               last;
  } out_t;

  typedef struct packed {
    logic load_item;
    logic exec_en;
    logic scan_en;
    logic emit_idle;
    logic idx_clr;
    logic idx_inc;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e item_cmd;
    logic speed_emit;
    logic out_free;
    logic idx_last;
    logic mask_empty;
    logic mask_hit;
  } dp_sts_t;

endpackage

### hdl/rcpiq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC pulse input qualifier controller
// Sequences one transaction at a time: execute, or scan then emit for ticks.
// ----------------------------------------------------------------------------
module rcpiq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rcpiq_pkg::dp_sts_t sts_i,
  output rcpiq_pkg::dp_cmd_t cmd_o
);
  import rcpiq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.item_cmd)
          CMD_TICK:   state_d = S_SCAN;
          CMD_UNUSED: state_d = S_IDLE;
          default: begin
            if (!sts_i.speed_emit || sts_i.out_free) begin
              state_d = S_IDLE;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (sts_i.idx_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.mask_empty) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
        cmd_o.idx_clr   = 1'b1;
      end
      S_EXEC: begin
        if (sts_i.item_cmd == CMD_CAPTURE || sts_i.item_cmd == CMD_POLL) begin
          cmd_o.exec_en = !sts_i.speed_emit || sts_i.out_free;
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        cmd_o.idx_clr = sts_i.idx_last;
        cmd_o.idx_inc = !sts_i.idx_last;
      end
      S_EMIT: begin
        if (!sts_i.mask_empty) begin
          if (sts_i.mask_hit) begin
            cmd_o.emit_idle = sts_i.out_free;
            cmd_o.idx_inc   = sts_i.out_free;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(cmd_o.scan_en || cmd_o.exec_en || cmd_o.emit_idle))
    else $error("ready raised while a transaction is in work");

  a_scan_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && sts_i.idx_last) |=> state_q == S_EMIT)
    else $error("scan end did not move to emit");

  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec_en |=> state_q == S_IDLE)
    else $error("execute did not return to idle");

endmodule

### hdl/rcpiq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC pulse input qualifier datapath
// Holds configuration, per-channel state, the item register and result register.
// ----------------------------------------------------------------------------
module rcpiq_dp #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rcpiq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rcpiq_pkg::CfgDataW-1:0]   cfg_data_i,
  input  rcpiq_pkg::in_t                   in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rcpiq_pkg::out_t                  out_data_o,
  input  rcpiq_pkg::dp_cmd_t               cmd_i,
  output rcpiq_pkg::dp_sts_t               sts_o
);
  import rcpiq_pkg::*;

  localparam int unsigned IdxW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned Depth = 2 ** IdxW;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(CHANNELS - 1);

  logic [15:0] min_width_q, overflow_limit_q, center_offset_q;
  logic [3:0]  good_needed_q;
  logic [7:0]  idle_limit_q;

  in_t             item_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [Depth-1:0] mask_q, mask_d;
  logic [Depth-1:0] ovf_q, ovf_d;
  logic [3:0]  good_q [Depth];
  logic [3:0]  good_d [Depth];
  logic [7:0]  idle_q [Depth];
  logic [7:0]  idle_d [Depth];
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  logic [IdxW-1:0] addr;
  logic        chan_ok;
  logic        reject;
  logic        need_more;
  logic [7:0]  idle_inc;
  logic        idle_hit;
  logic        out_free;
  logic        load_speed;
  logic [Depth-1:0] mask_rest;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_width_q      <= MinWidthRst;
      overflow_limit_q <= OverflowLimitRst;
      good_needed_q    <= GoodNeededRst;
      idle_limit_q     <= IdleLimitRst;
      center_offset_q  <= CenterOffsetRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_WIDTH:      min_width_q      <= cfg_data_i;
        CFG_OVERFLOW_LIMIT: overflow_limit_q <= cfg_data_i;
        CFG_GOOD_NEEDED:    good_needed_q    <= cfg_data_i[3:0];
        CFG_IDLE_LIMIT:     idle_limit_q     <= cfg_data_i[7:0];
        CFG_CENTER_OFFSET:  center_offset_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
  end

  assign addr      = (item_q.cmd == CMD_TICK) ? idx_q : IdxW'(item_q.channel);
  assign chan_ok   = {31'd0, item_q.channel} < 32'(CHANNELS);
  assign reject    = ovf_q[addr] || (item_q.pulse_width < min_width_q);
  assign need_more = good_q[addr] < good_needed_q;
  assign idle_inc  = idle_q[addr] + 8'd1;
  assign idle_hit  = idle_inc >= idle_limit_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign load_speed = cmd_i.exec_en && item_q.cmd == CMD_CAPTURE && chan_ok
                      && !reject && !need_more;
  assign mask_rest = mask_q & ~(Depth'(1) << idx_q);

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_comb begin
    ovf_d  = ovf_q;
    good_d = good_q;
    idle_d = idle_q;
    mask_d = mask_q;
    if (cmd_i.load_item) begin
      mask_d = '0;
    end
    if (cmd_i.exec_en && chan_ok) begin
      if (item_q.cmd == CMD_CAPTURE) begin
        if (reject) begin
          ovf_d[addr]  = 1'b0;
          good_d[addr] = '0;
        end else if (need_more) begin
          good_d[addr] = good_q[addr] + 4'd1;
        end else begin
          idle_d[addr] = '0;
        end
      end else if (item_q.pin_high && item_q.counter_value > overflow_limit_q) begin
        ovf_d[addr] = 1'b1;
      end
    end
    if (cmd_i.scan_en) begin
      if (idle_hit) begin
        idle_d[addr] = '0;
        good_d[addr] = '0;
        mask_d[addr] = 1'b1;
      end else begin
        idle_d[addr] = idle_inc;
      end
    end
    if (cmd_i.emit_idle) begin
      mask_d = mask_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      mask_q      <= '0;
      ovf_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Depth; i++) begin
        good_q[i] <= '0;
        idle_q[i] <= '0;
      end
    end else begin
      idx_q       <= idx_d;
      mask_q      <= mask_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      good_q      <= good_d;
      idle_q      <= idle_d;
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load_speed) begin
      out_valid_d       = 1'b1;
      out_d.kind        = KIND_SPEED;
      out_d.out_channel = item_q.channel;
      out_d.speed       = item_q.pulse_width - center_offset_q;
      out_d.last        = 1'b1;
    end else if (cmd_i.emit_idle) begin
      out_valid_d       = 1'b1;
      out_d.kind        = KIND_IDLE;
      out_d.out_channel = idx_q[0];
      out_d.speed       = '0;
      out_d.last        = (mask_rest == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.item_cmd   = item_q.cmd;
  assign sts_o.speed_emit = item_q.cmd == CMD_CAPTURE && chan_ok && !reject && !need_more;
  assign sts_o.out_free   = out_free;
  assign sts_o.idx_last   = idx_q == IdxLast;
  assign sts_o.mask_empty = mask_q == '0;
  assign sts_o.mask_hit   = mask_q[idx_q];

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_speed || cmd_i.emit_idle) |-> out_free)
    else $error("result register loaded while occupied");

  a_last_empties_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_idle && mask_rest == '0) |=> mask_q == '0)
    else $error("final idle result left channels pending");

  a_scan_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_en && !cfg_we_i) |=> (idle_q[$past(addr)] < idle_limit_q
                                      || idle_q[$past(addr)] == '0))
    else $error("idle count left at or above limit after scan");

endmodule

### hdl/rc_pulse_input_qualifier.sv
`timescale 1ns / 1ps
// Capture and poll pass through accept, then execute; a speed shows on
// the output register the cycle after execute. Tick passes through accept,
// execute, a scan of all channels, then emit, one report per timed-out channel.
// One transaction in work at a time; a held result stalls a speed-making
// execute and an idle report until the output frees. Reset is asynchronous,
// active low; it clears all channel state and loads register reset values.
// ----------------------------------------------------------------------------
// RC pulse input qualifier
// Per-channel pulse width qualification with overflow, warm-up and idle timeout.
// ----------------------------------------------------------------------------
module rc_pulse_input_qualifier #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcpiq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rcpiq_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rcpiq_pkg::in_t                 in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rcpiq_pkg::out_t                out_data_o
);
  import rcpiq_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  rcpiq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  rcpiq_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts)
  );

endmodule

### test/rc_pulse_input_qualifier_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC pulse input qualifier result checker
// Watches the register port and both transaction channels. Keeps its own copy
// of the registers and of the per-channel overflow, warm-up and idle state,
// works out the speed and idle reports each accepted transaction causes, and
// compares every accepted result field by field with the oldest one due.
// ----------------------------------------------------------------------------
module rc_pulse_input_qualifier_checker #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcpiq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rcpiq_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  rcpiq_pkg::in_t                 in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  rcpiq_pkg::out_t                out_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    outstanding_o,
  output int unsigned                    checked_o
);
  import rcpiq_pkg::*;

  logic [15:0] min_width_q;
  logic [15:0] overflow_limit_q;
  logic [3:0]  good_needed_q;
  logic [7:0]  idle_limit_q;
  logic [15:0] center_offset_q;

  logic        overflow_seen [CHANNELS];
  logic [3:0]  good_pulses   [CHANNELS];
  logic [7:0]  idle_age      [CHANNELS];

  out_t        due_reports_q[$];
  out_t        want;
  int unsigned mismatches = 0;
  int unsigned checked    = 0;

  function automatic void qualify_pulse_item(input in_t item);
    out_t rep;
    out_t idle_rep [CHANNELS];
    int   n_idle;
    n_idle = 0;
    rep    = '0;
    case (item.cmd)
      CMD_CAPTURE: begin
        if (item.channel < CHANNELS) begin
          if (overflow_seen[item.channel] || item.pulse_width < min_width_q) begin
            overflow_seen[item.channel] = 1'b0;
            good_pulses[item.channel]   = '0;
          end else if (good_pulses[item.channel] < good_needed_q) begin
            good_pulses[item.channel] = good_pulses[item.channel] + 4'd1;
          end else begin
            idle_age[item.channel] = '0;
            rep.kind        = KIND_SPEED;
            rep.out_channel = item.channel;
            rep.speed       = item.pulse_width - center_offset_q;
            rep.last        = 1'b1;
            due_reports_q.push_back(rep);
          end
        end
      end
      CMD_POLL: begin
        if (item.channel < CHANNELS && item.pin_high &&
            item.counter_value > overflow_limit_q) begin
          overflow_seen[item.channel] = 1'b1;
        end
      end
      CMD_TICK: begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          idle_age[ch] = idle_age[ch] + 8'd1;
          if (idle_age[ch] >= idle_limit_q) begin
            idle_age[ch]    = '0;
            good_pulses[ch] = '0;
            idle_rep[n_idle]             = '0;
            idle_rep[n_idle].kind        = KIND_IDLE;
            idle_rep[n_idle].out_channel = 1'(ch);
            n_idle++;
          end
        end
        for (int k = 0; k < n_idle; k++) begin
          rep      = idle_rep[k];
          rep.last = (k == n_idle - 1);
          due_reports_q.push_back(rep);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(input string field,
                                        input logic signed [16:0] expected_val,
                                        input logic signed [16:0] actual_val);
    $display("%0t: %s mismatch, expected %0d, actual %0d",
             $time, field, expected_val, actual_val);
    mismatches++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_width_q      = MinWidthRst;
      overflow_limit_q = OverflowLimitRst;
      good_needed_q    = GoodNeededRst;
      idle_limit_q     = IdleLimitRst;
      center_offset_q  = CenterOffsetRst;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        overflow_seen[ch] = 1'b0;
        good_pulses[ch]   = '0;
        idle_age[ch]      = '0;
      end
      due_reports_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_reports_q.size() == 0) begin
          $display("%0t: result with none due, actual kind %0d channel %0d speed %0d last %0d",
                   $time, out_data_i.kind, out_data_i.out_channel, out_data_i.speed,
                   out_data_i.last);
          mismatches++;
        end else begin
          want = due_reports_q.pop_front();
          if (out_data_i.kind !== want.kind)
            note_mismatch("kind", want.kind, out_data_i.kind);
          if (out_data_i.out_channel !== want.out_channel)
            note_mismatch("out_channel", want.out_channel, out_data_i.out_channel);
          if (out_data_i.speed !== want.speed)
            note_mismatch("speed", want.speed, out_data_i.speed);
          if (out_data_i.last !== want.last)
            note_mismatch("last", want.last, out_data_i.last);
          checked++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        qualify_pulse_item(in_data_i);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_WIDTH:      min_width_q      = cfg_data_i[15:0];
          CFG_OVERFLOW_LIMIT: overflow_limit_q = cfg_data_i[15:0];
          CFG_GOOD_NEEDED:    good_needed_q    = cfg_data_i[3:0];
          CFG_IDLE_LIMIT:     idle_limit_q     = cfg_data_i[7:0];
          CFG_CENTER_OFFSET:  center_offset_q  = cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
    fail_count_o  <= mismatches;
    outstanding_o <= due_reports_q.size();
    checked_o     <= checked;
  end

endmodule

### test/rc_pulse_input_qualifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC pulse input qualifier testbench
// Drives capture, poll and tick transactions with random gaps and output
// stalls, including one long output hold-off, through directed corner cases
// and a series of register settings, and lets the checker judge every result.
// ----------------------------------------------------------------------------
module rc_pulse_input_qualifier_test;
  import rcpiq_pkg::*;

  localparam int unsigned Channels       = 2;
  localparam int unsigned RandomPhases   = 6;
  localparam int unsigned PhaseItems     = 70;
  localparam int unsigned PressurePhase  = 2;
  localparam int unsigned SettleCycles   = 12;
  localparam int unsigned LongHoldCycles = 200;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_t                 in_data  = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned sent         = 0;
  int unsigned settings     = 0;
  int unsigned quiet_cycles = 0;
  bit          send_eager   = 1'b0;
  bit          take_eager   = 1'b0;
  bit          hold_off_req = 1'b0;
  logic [15:0] cur_min_width      = MinWidthRst;
  logic [15:0] cur_overflow_limit = OverflowLimitRst;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rc_pulse_input_qualifier #(
    .CHANNELS(Channels)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  rc_pulse_input_qualifier_checker #(
    .CHANNELS(Channels)
  ) pulse_watch (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding),
    .checked_o    (checked)
  );

  function automatic in_t make_item(input cmd_e cmd, input logic ch, input logic [15:0] width,
                                    input logic pin, input logic [15:0] count);
    in_t it;
    it.cmd           = cmd;
    it.channel       = ch;
    it.pulse_width   = width;
    it.pin_high      = pin;
    it.counter_value = count;
    return it;
  endfunction

  function automatic in_t random_item();
    in_t         it;
    int unsigned pick;
    it.channel       = 1'($urandom_range(0, 1));
    it.pulse_width   = 16'($urandom_range(0, 65535));
    it.pin_high      = 1'($urandom_range(0, 1));
    it.counter_value = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it.cmd         = CMD_CAPTURE;
      it.pulse_width = 16'($urandom_range(cur_min_width, 65535));
    end else if (pick < 68) begin
      it.cmd = CMD_CAPTURE;
    end else if (pick < 80) begin
      it.cmd = CMD_POLL;
      if (pick < 74) begin
        it.counter_value = cur_overflow_limit + 16'($urandom_range(0, 3)) - 16'd1;
      end
    end else if (pick < 96) begin
      it.cmd = CMD_TICK;
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic send_item(input in_t item);
    int unsigned gap;
    gap = send_eager ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic program_setting(input logic [15:0] min_w, input logic [15:0] ovf_lim,
                                 input logic [15:0] good_n, input logic [15:0] idle_lim,
                                 input logic [15:0] center);
    write_reg(CFG_MIN_WIDTH, min_w);
    write_reg(CFG_OVERFLOW_LIMIT, ovf_lim);
    write_reg(CFG_GOOD_NEEDED, good_n);
    write_reg(CFG_IDLE_LIMIT, idle_lim);
    write_reg(CFG_CENTER_OFFSET, center);
    cfg_we <= 1'b0;
    cur_min_width      = min_w;
    cur_overflow_limit = ovf_lim;
    settings++;
  endtask

  task automatic apply_random_setting();
    logic [15:0] min_w;
    logic [15:0] ovf_lim;
    logic [15:0] good_n;
    logic [15:0] idle_lim;
    logic [15:0] center;
    min_w   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6000));
    ovf_lim = 16'($urandom);
    good_n  = 16'($urandom);
    good_n[3:0] = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
    idle_lim = 16'($urandom);
    case ($urandom_range(0, 9))
      0: idle_lim[7:0] = 8'd1;
      1: idle_lim[7:0] = 8'd255;
      default: idle_lim[7:0] = 8'($urandom_range(2, 24));
    endcase
    center = 16'($urandom);
    program_setting(min_w, ovf_lim, good_n, idle_lim, center);
  endtask

  initial begin : receiver
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
      end
      stall = take_eager ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog, no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, outstanding);
      $display("rc_pulse_input_qualifier_test NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(make_item(CMD_CAPTURE, 1'b0, 16'd0, 1'b0, 16'd0));
    send_item(make_item(CMD_POLL, 1'b0, 16'd0, 1'b1, 16'hFFFF));
    send_item(make_item(CMD_CAPTURE, 1'b0, 16'hFFFF, 1'b0, 16'd0));
    send_item(make_item(CMD_POLL, 1'b1, 16'd0, 1'b1, 16'd25000));
    send_item(make_item(CMD_POLL, 1'b1, 16'd0, 1'b1, 16'd25001));
    send_item(make_item(CMD_CAPTURE, 1'b1, 16'd4000, 1'b0, 16'd0));
    send_item(make_item(CMD_CAPTURE, 1'b1, 16'd4000, 1'b0, 16'd0));
    send_item(make_item(CMD_CAPTURE, 1'b1, 16'd3999, 1'b0, 16'd0));
    repeat (8) send_item(make_item(CMD_TICK, 1'b0, 16'd0, 1'b0, 16'd0));
    settle();

    program_setting(16'd0, 16'd0, 16'd0, 16'd1, 16'd0);
    send_item(make_item(CMD_CAPTURE, 1'b0, 16'd0, 1'b0, 16'd0));
    send_item(make_item(CMD_CAPTURE, 1'b1, 16'hFFFF, 1'b0, 16'd0));
    send_item(make_item(CMD_TICK, 1'b1, 16'd0, 1'b0, 16'd0));
    send_item(make_item(CMD_POLL, 1'b0, 16'd0, 1'b1, 16'd1));
    send_item(make_item(CMD_CAPTURE, 1'b0, 16'hFFFF, 1'b0, 16'd0));
    send_item(make_item(CMD_UNUSED, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF));
    settle();

    program_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(make_item(CMD_CAPTURE, 1'b0, 16'hFFFF, 1'b0, 16'd0));
    send_item(make_item(CMD_CAPTURE, 1'b1, 16'hFFFE, 1'b0, 16'd0));
    send_item(make_item(CMD_POLL, 1'b0, 16'd0, 1'b1, 16'hFFFF));
    settle();

    write_reg(CFG_IDLE_LIMIT, 16'hFF00);
    write_reg(CfgIdxSpare, 16'hFFFF);
    cfg_we <= 1'b0;
    settings++;
    send_item(make_item(CMD_TICK, 1'b0, 16'd0, 1'b0, 16'd0));
    send_item(make_item(CMD_TICK, 1'b1, 16'd0, 1'b0, 16'd0));
    settle();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      apply_random_setting();
      send_eager = ($urandom_range(0, 3) == 0);
      take_eager = ($urandom_range(0, 3) == 0);
      if (phase == PressurePhase) begin
        send_eager   = 1'b1;
        take_eager   = 1'b0;
        hold_off_req = 1'b1;
      end
      repeat (PhaseItems) send_item(random_item());
      settle();
    end

    $display("Covered %0d capture/poll/tick transactions over %0d register settings,",
             sent, settings);
    $display("with %0d results checked and %0d mismatches.", checked, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("rc_pulse_input_qualifier_test OK");
    end else begin
      $display("rc_pulse_input_qualifier_test NOT OK");
    end
    $finish;
  end

endmodule
